### hw/rtl/wtsa_pkg.sv
// Shared types and constants of the web trace statistics accumulator.
package wtsa_pkg;

  // Function codes carried by an input transaction
  typedef enum logic [1:0] {
    FUNC_RECORD      = 2'd0,
    FUNC_READ_STAT   = 2'd1,
    FUNC_READ_SERVER = 2'd2,
    FUNC_NONE        = 2'd3
  } func_t;

  // Statistic selector codes
  localparam logic [3:0] STAT_REQUESTS = 4'd0;
  localparam logic [3:0] STAT_BYTES    = 4'd1;
  localparam logic [3:0] STAT_SIZE_MIN = 4'd2;
  localparam logic [3:0] STAT_SIZE_MAX = 4'd3;
  localparam logic [3:0] STAT_CLI_MIN  = 4'd4;
  localparam logic [3:0] STAT_CLI_MAX  = 4'd5;
  localparam logic [3:0] STAT_OBJ_MIN  = 4'd6;
  localparam logic [3:0] STAT_OBJ_MAX  = 4'd7;
  localparam logic [3:0] STAT_TIME_MIN = 4'd8;
  localparam logic [3:0] STAT_TIME_MAX = 4'd9;
  localparam logic [3:0] STAT_FIRST    = 4'd10;
  localparam logic [3:0] STAT_LAST     = 4'd11;
  localparam logic [3:0] STAT_DISORDER = 4'd12;
  localparam logic [3:0] STAT_SERVERS  = 4'd13;

  // Server counter store geometry
  localparam int SERVER_SLOTS = 256;
  localparam int SERVER_BITS  = $clog2(SERVER_SLOTS);
  localparam int UNIQUE_BITS  = 9;

  // Field constants
  localparam logic [31:0] SIZE_UNKNOWN  = 32'hFFFF_FFFF;
  localparam logic [2:0]  REGION_LIMIT  = 3'd4;
  localparam logic [5:0]  RETURN_LIMIT  = 6'd38;
  localparam logic [7:0]  METHOD_LIMIT  = 8'd9;
  localparam logic [7:0]  TYPE_LIMIT    = 8'd13;

  // One input transaction as held in the work stage
  typedef struct packed {
    func_t       func;
    logic [31:0] stamp;
    logic [31:0] client_code;
    logic [31:0] object_code;
    logic [31:0] xfer_size;
    logic [7:0]  server_byte;
    logic [7:0]  status_byte;
    logic [7:0]  method_code;
    logic [7:0]  type_code;
    logic [3:0]  stat_select;
  } item_t;

  // Control from the pipeline to the counter store
  typedef struct packed {
    logic                   rd_en;
    logic [SERVER_BITS-1:0] rd_addr;
    logic                   wr_en;
    logic [SERVER_BITS-1:0] cur_addr;
  } store_ctl_t;

endpackage

### hw/rtl/wtsa_if.sv
// Valid/ready channel interfaces for record input and result output.
interface wtsa_rec_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [31:0]        stamp;
  logic [31:0]        client_code;
  logic [31:0]        object_code;
  logic signed [31:0] xfer_size;
  logic [7:0]         server_byte;
  logic [7:0]         status_byte;
  logic [7:0]         method_code;
  logic [7:0]         type_code;
  logic [3:0]         stat_select;

  modport source (
    output valid, func, stamp, client_code, object_code, xfer_size,
           server_byte, status_byte, method_code, type_code, stat_select,
    input  ready
  );
  modport sink (
    input  valid, func, stamp, client_code, object_code, xfer_size,
           server_byte, status_byte, method_code, type_code, stat_select,
    output ready
  );
endinterface

interface wtsa_res_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] read_value;
  logic [3:0]         check_flags;

  modport source (output valid, read_value, check_flags, input ready);
  modport sink (input valid, read_value, check_flags, output ready);
endinterface

### hw/rtl/wtsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module wtsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### hw/rtl/wtsa_server_store.sv
// Per-server request counters: RAM, fill flags and write forwarding.
module wtsa_server_store #(
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wtsa_pkg::store_ctl_t   ctl,
  output logic [COUNT_BITS-1:0]  count,
  output logic                   count_zero
);
  localparam int AB = wtsa_pkg::SERVER_BITS;

  logic [COUNT_BITS-1:0]             ram_q;
  logic [COUNT_BITS-1:0]             count_inc;
  logic [wtsa_pkg::SERVER_SLOTS-1:0] filled;
  logic                              fwd_valid;
  logic [AB-1:0]                     fwd_addr;
  logic [COUNT_BITS-1:0]             fwd_data;

  wtsa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (wtsa_pkg::SERVER_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (ctl.cur_addr),
    .wdata (count_inc),
    .re    (ctl.rd_en),
    .raddr (ctl.rd_addr),
    .rdata (ram_q)
  );

  // Current count: forwarded write, else RAM, else zero for a never-written slot
  always_comb begin
    if (fwd_valid && (fwd_addr == ctl.cur_addr)) begin
      count = fwd_data;
    end else if (filled[ctl.cur_addr]) begin
      count = ram_q;
    end else begin
      count = '0;
    end
  end

  assign count_inc  = count + COUNT_BITS'(1);
  assign count_zero = (count == '0);

  // Fill flags, cleared together at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (ctl.wr_en) begin
      filled[ctl.cur_addr] <= 1'b1;
    end
  end

  // The write landing on the edge of a new read is missed by that read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (ctl.wr_en) begin
      fwd_valid <= 1'b1;
    end else if (ctl.rd_en) begin
      fwd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      fwd_addr <= ctl.cur_addr;
      fwd_data <= count_inc;
    end
  end
endmodule

### hw/rtl/wtsa_stats.sv
// Running scalar statistics and the statistic read selector.
module wtsa_stats #(
  parameter int COUNT_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            upd,
  input  logic            new_server,
  input  wtsa_pkg::item_t item,
  output logic [63:0]     stat_value
);
  logic [COUNT_BITS-1:0]            request_total;
  logic [63:0]                      byte_total;
  logic [31:0]                      size_min, size_max;
  logic [31:0]                      client_min, client_max;
  logic [31:0]                      object_min, object_max;
  logic [31:0]                      time_min, time_max;
  logic [31:0]                      first_stamp;
  logic                             first_seen;
  logic [31:0]                      last_stamp;
  logic [COUNT_BITS-1:0]            disorder_total;
  logic [wtsa_pkg::UNIQUE_BITS-1:0] unique_servers;
  logic                             size_known;
  logic [63:0]                      size_ext;

  assign size_known = (item.xfer_size != wtsa_pkg::SIZE_UNKNOWN);
  assign size_ext   = {{32{item.xfer_size[31]}}, item.xfer_size};

  // Accumulate one record
  always_ff @(posedge clk) begin
    if (rst) begin
      request_total  <= '0;
      byte_total     <= '0;
      size_min       <= '1;
      size_max       <= '0;
      client_min     <= '1;
      client_max     <= '0;
      object_min     <= '1;
      object_max     <= '0;
      time_min       <= '1;
      time_max       <= '0;
      first_stamp    <= '1;
      first_seen     <= 1'b0;
      last_stamp     <= '0;
      disorder_total <= '0;
      unique_servers <= '0;
    end else if (upd) begin
      if (!first_seen) begin
        first_stamp <= item.stamp;
        first_seen  <= 1'b1;
      end
      request_total <= request_total + COUNT_BITS'(1);
      if (size_known) begin
        byte_total <= byte_total + size_ext;
        if (item.xfer_size < size_min) size_min <= item.xfer_size;
        if (item.xfer_size > size_max) size_max <= item.xfer_size;
      end
      if (item.stamp < last_stamp) begin
        disorder_total <= disorder_total + COUNT_BITS'(1);
      end
      last_stamp <= item.stamp;
      if (item.stamp < time_min) time_min <= item.stamp;
      if (item.stamp > time_max) time_max <= item.stamp;
      if (item.object_code < object_min) object_min <= item.object_code;
      if (item.object_code > object_max) object_max <= item.object_code;
      if (item.client_code < client_min) client_min <= item.client_code;
      if (item.client_code > client_max) client_max <= item.client_code;
      if (new_server) begin
        unique_servers <= unique_servers + wtsa_pkg::UNIQUE_BITS'(1);
      end
    end
  end

  // Statistic selector, unused codes read zero
  always_comb begin
    case (item.stat_select)
      wtsa_pkg::STAT_REQUESTS: stat_value = 64'(request_total);
      wtsa_pkg::STAT_BYTES:    stat_value = byte_total;
      wtsa_pkg::STAT_SIZE_MIN: stat_value = 64'(size_min);
      wtsa_pkg::STAT_SIZE_MAX: stat_value = 64'(size_max);
      wtsa_pkg::STAT_CLI_MIN:  stat_value = 64'(client_min);
      wtsa_pkg::STAT_CLI_MAX:  stat_value = 64'(client_max);
      wtsa_pkg::STAT_OBJ_MIN:  stat_value = 64'(object_min);
      wtsa_pkg::STAT_OBJ_MAX:  stat_value = 64'(object_max);
      wtsa_pkg::STAT_TIME_MIN: stat_value = 64'(time_min);
      wtsa_pkg::STAT_TIME_MAX: stat_value = 64'(time_max);
      wtsa_pkg::STAT_FIRST:    stat_value = 64'(first_stamp);
      wtsa_pkg::STAT_LAST:     stat_value = 64'(last_stamp);
      wtsa_pkg::STAT_DISORDER: stat_value = 64'(disorder_total);
      wtsa_pkg::STAT_SERVERS:  stat_value = 64'(unique_servers);
      default:                 stat_value = '0;
    endcase
  end
endmodule

### hw/rtl/web_trace_stats_accumulator.sv
// Top level of the web trace statistics accumulator.
// Accepts one transaction per clock while results are taken, a rate set by
// the single read and single write port of the per-server counter RAM: the
// counter is read on acceptance and written back from the work stage, and a
// record directly behind a record of the same server takes its count from a
// forwarding register. Exactly one result per transaction is returned, in
// order, from an output register loaded as it leaves the work stage. The
// output register parts the two channels, so a new transaction is taken
// while a result waits. Record transactions return zero in read_value and
// the four field-check flags; read transactions return the selected
// statistic or server counter with zero flags. Reset clears all 256 counter
// fill flags at once; no clearing pass follows, and the block is ready right
// after reset.
module web_trace_stats_accumulator_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic              clk,
  input  logic              rst,
  wtsa_rec_if.sink          rec,
  wtsa_res_if.source        res
);
  wtsa_pkg::item_t      s1_item;
  logic                 s1_valid;
  logic                 accept;
  logic                 advance;
  logic                 is_record;
  wtsa_pkg::store_ctl_t store_ctl;
  logic [COUNT_BITS-1:0] srv_count;
  logic                 srv_zero;
  logic [63:0]          stat_value;
  logic [3:0]           flags;
  logic [63:0]          value_next;
  logic [3:0]           flags_next;
  logic                 out_valid;
  logic [63:0]          read_value;
  logic [3:0]           check_flags;

  // Handshake
  assign advance   = s1_valid && (!out_valid || res.ready);
  assign rec.ready = !s1_valid || advance;
  assign accept    = rec.valid && rec.ready;
  assign is_record = (s1_item.func == wtsa_pkg::FUNC_RECORD);

  // Work stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rec.ready) begin
      s1_valid <= rec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item.func        <= wtsa_pkg::func_t'(rec.func);
      s1_item.stamp       <= rec.stamp;
      s1_item.client_code <= rec.client_code;
      s1_item.object_code <= rec.object_code;
      s1_item.xfer_size   <= rec.xfer_size;
      s1_item.server_byte <= rec.server_byte;
      s1_item.status_byte <= rec.status_byte;
      s1_item.method_code <= rec.method_code;
      s1_item.type_code   <= rec.type_code;
      s1_item.stat_select <= rec.stat_select;
    end
  end

  // Counter store
  assign store_ctl.rd_en    = accept;
  assign store_ctl.rd_addr  = rec.server_byte[wtsa_pkg::SERVER_BITS-1:0];
  assign store_ctl.wr_en    = advance && is_record;
  assign store_ctl.cur_addr = s1_item.server_byte[wtsa_pkg::SERVER_BITS-1:0];

  wtsa_server_store #(
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (store_ctl),
    .count      (srv_count),
    .count_zero (srv_zero)
  );

  wtsa_stats #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk        (clk),
    .rst        (rst),
    .upd        (advance && is_record),
    .new_server (srv_zero),
    .item       (s1_item),
    .stat_value (stat_value)
  );

  // Field checks
  assign flags[0] = (s1_item.server_byte[7:5] >= wtsa_pkg::REGION_LIMIT);
  assign flags[1] = (s1_item.status_byte[5:0] >= wtsa_pkg::RETURN_LIMIT);
  assign flags[2] = (s1_item.method_code >= wtsa_pkg::METHOD_LIMIT);
  assign flags[3] = (s1_item.type_code >= wtsa_pkg::TYPE_LIMIT);

  // Result selection
  always_comb begin
    value_next = '0;
    flags_next = '0;
    case (s1_item.func)
      wtsa_pkg::FUNC_RECORD:      flags_next = flags;
      wtsa_pkg::FUNC_READ_STAT:   value_next = stat_value;
      wtsa_pkg::FUNC_READ_SERVER: value_next = 64'(srv_count);
      default: begin
        value_next = '0;
        flags_next = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_value  <= value_next;
      check_flags <= flags_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.read_value  = $signed(read_value);
  assign res.check_flags = check_flags;
endmodule

### hw/rtl/wtsa_checker.sv
// Port-level checker of the accumulator, bound to the top level.
module wtsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        rec_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [63:0] res_value,
  input logic [3:0]  res_flags
);
  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Input side is ready right after reset
  a_reset_ready: assert property (@(posedge clk) rst |=> rec_ready)
    else $error("input not ready after reset");

  // A result carries either a read value or flags, never both
  a_value_or_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_value == 64'd0) || (res_flags == 4'd0))
    else $error("result has both a value and flags");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_flags))
    else $error("stalled result changed");
endmodule

bind web_trace_stats_accumulator_core wtsa_checker u_wtsa_checker (
  .clk       (clk),
  .rst       (rst),
  .rec_ready (rec.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_value (res.read_value),
  .res_flags (res.check_flags)
);

### tb/sv/web_trace_stats_accumulator_core_test.sv
// Self-checking testbench for the web trace statistics accumulator core.
module web_trace_stats_accumulator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_BITS    = 32;
  localparam int RANDOM_ITEMS  = 450;
  localparam int IDLE_PCT      = 23;
  localparam int HOLD_AT       = 120;   // result count that starts the long output stall
  localparam int HOLD_CYCLES   = 60;
  localparam int PRINT_LIMIT   = 30;

  // Expected result of one transaction
  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  flags;
  } readout_t;

  logic clk;
  logic rst;

  wtsa_rec_if rec_if ();
  wtsa_res_if res_if ();

  web_trace_stats_accumulator_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .rec(rec_if),
    .res(res_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stimulus and expectation stores
  wtsa_pkg::item_t record_queue[$];
  readout_t        due_results[$];
  wtsa_pkg::item_t cur_item;

  // Shadow statistics
  logic [COUNT_BITS-1:0] req_cnt;
  logic [63:0]           byte_sum;
  logic [31:0]           size_lo, size_hi;
  logic [31:0]           cli_lo, cli_hi;
  logic [31:0]           obj_lo, obj_hi;
  logic [31:0]           t_lo, t_hi;
  logic [31:0]           first_t, last_t;
  bit                    seen_first;
  logic [COUNT_BITS-1:0] disorder_cnt;
  logic [8:0]            server_seen;
  logic [COUNT_BITS-1:0] per_server [wtsa_pkg::SERVER_SLOTS];

  int err_cnt;
  int sent_cnt;
  int got_cnt;
  int hold_left;
  int n_records, n_stat_reads, n_srv_reads, n_unused;

  // Generator state
  logic [31:0] gen_stamp;
  logic [7:0]  gen_srv;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_cnt < PRINT_LIMIT)
      $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Apply one transaction to the shadow statistics and return its result
  function automatic readout_t update_trace_stats(input wtsa_pkg::item_t it);
    readout_t r;
    logic [31:0] sz;
    r.value = '0;
    r.flags = '0;
    sz = it.xfer_size;
    case (it.func)
      wtsa_pkg::FUNC_READ_STAT: begin
        n_stat_reads++;
        case (it.stat_select)
          wtsa_pkg::STAT_REQUESTS: r.value = 64'(req_cnt);
          wtsa_pkg::STAT_BYTES:    r.value = byte_sum;
          wtsa_pkg::STAT_SIZE_MIN: r.value = 64'(size_lo);
          wtsa_pkg::STAT_SIZE_MAX: r.value = 64'(size_hi);
          wtsa_pkg::STAT_CLI_MIN:  r.value = 64'(cli_lo);
          wtsa_pkg::STAT_CLI_MAX:  r.value = 64'(cli_hi);
          wtsa_pkg::STAT_OBJ_MIN:  r.value = 64'(obj_lo);
          wtsa_pkg::STAT_OBJ_MAX:  r.value = 64'(obj_hi);
          wtsa_pkg::STAT_TIME_MIN: r.value = 64'(t_lo);
          wtsa_pkg::STAT_TIME_MAX: r.value = 64'(t_hi);
          wtsa_pkg::STAT_FIRST:    r.value = 64'(first_t);
          wtsa_pkg::STAT_LAST:     r.value = 64'(last_t);
          wtsa_pkg::STAT_DISORDER: r.value = 64'(disorder_cnt);
          wtsa_pkg::STAT_SERVERS:  r.value = 64'(server_seen);
          default:                 r.value = '0;
        endcase
      end
      wtsa_pkg::FUNC_READ_SERVER: begin
        n_srv_reads++;
        r.value = 64'(per_server[it.server_byte]);
      end
      wtsa_pkg::FUNC_RECORD: begin
        n_records++;
        if (!seen_first) begin
          first_t    = it.stamp;
          seen_first = 1'b1;
        end
        req_cnt = req_cnt + 1'b1;
        // unknown size leaves the byte statistics alone
        if (sz != wtsa_pkg::SIZE_UNKNOWN) begin
          byte_sum = byte_sum + {{32{sz[31]}}, sz};
          if (sz < size_lo) size_lo = sz;
          if (sz > size_hi) size_hi = sz;
        end
        if (it.stamp < last_t) disorder_cnt = disorder_cnt + 1'b1;
        last_t = it.stamp;
        if (it.stamp < t_lo) t_lo = it.stamp;
        if (it.stamp > t_hi) t_hi = it.stamp;
        if (it.object_code < obj_lo) obj_lo = it.object_code;
        if (it.object_code > obj_hi) obj_hi = it.object_code;
        if (it.client_code < cli_lo) cli_lo = it.client_code;
        if (it.client_code > cli_hi) cli_hi = it.client_code;
        if (per_server[it.server_byte] == '0) server_seen = server_seen + 1'b1;
        per_server[it.server_byte] = per_server[it.server_byte] + 1'b1;
        r.flags[0] = it.server_byte[7:5] >= wtsa_pkg::REGION_LIMIT;
        r.flags[1] = it.status_byte[5:0] >= wtsa_pkg::RETURN_LIMIT;
        r.flags[2] = it.method_code >= wtsa_pkg::METHOD_LIMIT;
        r.flags[3] = it.type_code >= wtsa_pkg::TYPE_LIMIT;
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  task automatic queue_record(input logic [31:0] stamp, input logic [31:0] cli,
                              input logic [31:0] obj, input logic [31:0] sz,
                              input logic [7:0] srv, input logic [7:0] status,
                              input logic [7:0] method, input logic [7:0] ftype);
    wtsa_pkg::item_t it;
    it = '0;
    it.func        = wtsa_pkg::FUNC_RECORD;
    it.stamp       = stamp;
    it.client_code = cli;
    it.object_code = obj;
    it.xfer_size   = sz;
    it.server_byte = srv;
    it.status_byte = status;
    it.method_code = method;
    it.type_code   = ftype;
    record_queue.push_back(it);
  endtask

  task automatic queue_read(input wtsa_pkg::func_t f, input logic [3:0] sel,
                            input logic [7:0] idx);
    wtsa_pkg::item_t it;
    it = '0;
    it.func        = f;
    it.stat_select = sel;
    it.server_byte = idx;
    record_queue.push_back(it);
  endtask

  // Random transaction: mostly plausible records, with reads mixed in
  function automatic wtsa_pkg::item_t random_item();
    wtsa_pkg::item_t it;
    int pick;
    pick = $urandom_range(99);
    it.stamp       = $urandom;
    it.client_code = ($urandom_range(1)) ? $urandom : 32'($urandom_range(1000));
    it.object_code = ($urandom_range(1)) ? $urandom : 32'($urandom_range(1000));
    it.status_byte = 8'($urandom_range(255));
    it.method_code = ($urandom_range(1)) ? 8'($urandom_range(8)) : 8'($urandom_range(255));
    it.type_code   = ($urandom_range(1)) ? 8'($urandom_range(12)) : 8'($urandom_range(255));
    it.stat_select = 4'($urandom_range(15));
    it.server_byte = 8'($urandom_range(255));
    it.xfer_size   = $urandom;
    if (pick < 60) begin
      it.func = wtsa_pkg::FUNC_RECORD;
      // mostly rising timestamps, some jumps backward or anywhere
      if ($urandom_range(99) < 70) gen_stamp = gen_stamp + 32'($urandom_range(50));
      else gen_stamp = $urandom;
      it.stamp = gen_stamp;
      pick = $urandom_range(99);
      if (pick < 15) it.xfer_size = wtsa_pkg::SIZE_UNKNOWN;
      else if (pick < 65) it.xfer_size = 32'($urandom_range(20000));
      else if (pick < 80) it.xfer_size = 32'h0 - 32'($urandom_range(5000, 2));
      // repeat the last server now and then to hit back-to-back updates
      pick = $urandom_range(99);
      if (pick < 20) it.server_byte = gen_srv;
      else if (pick < 70) it.server_byte = {3'($urandom_range(7)), 5'($urandom_range(3))};
      gen_srv = it.server_byte;
    end else if (pick < 85) begin
      it.func = wtsa_pkg::FUNC_READ_STAT;
    end else if (pick < 97) begin
      it.func = wtsa_pkg::FUNC_READ_SERVER;
      if ($urandom_range(1)) it.server_byte = gen_srv;
    end else begin
      it.func = wtsa_pkg::FUNC_NONE;
    end
    return it;
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      rec_if.valid <= 1'b0;
    end else begin
      if (rec_if.valid && rec_if.ready) begin
        due_results.push_back(update_trace_stats(cur_item));
        sent_cnt++;
      end
      if (!rec_if.valid || rec_if.ready) begin
        if (record_queue.size() != 0 &&
            ((sent_cnt >= 200 && sent_cnt < 300) || $urandom_range(99) >= IDLE_PCT)) begin
          cur_item = record_queue.pop_front();
          rec_if.valid       <= 1'b1;
          rec_if.func        <= cur_item.func;
          rec_if.stamp       <= cur_item.stamp;
          rec_if.client_code <= cur_item.client_code;
          rec_if.object_code <= cur_item.object_code;
          rec_if.xfer_size   <= cur_item.xfer_size;
          rec_if.server_byte <= cur_item.server_byte;
          rec_if.status_byte <= cur_item.status_byte;
          rec_if.method_code <= cur_item.method_code;
          rec_if.type_code   <= cur_item.type_code;
          rec_if.stat_select <= cur_item.stat_select;
        end else begin
          rec_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output back-pressure
  always @(posedge clk) begin
    readout_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected transaction", res_if.read_value, '0);
        end else begin
          want = due_results.pop_front();
          if (res_if.read_value !== want.value)
            report_mismatch("read_value", res_if.read_value, want.value);
          if (res_if.check_flags !== want.flags)
            report_mismatch("check_flags", 64'(res_if.check_flags), 64'(want.flags));
        end
        got_cnt++;
        if (got_cnt == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (got_cnt >= 300 && got_cnt < 400) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    rec_if.valid       = 1'b0;
    rec_if.func        = wtsa_pkg::FUNC_RECORD;
    rec_if.stamp       = '0;
    rec_if.client_code = '0;
    rec_if.object_code = '0;
    rec_if.xfer_size   = '0;
    rec_if.server_byte = '0;
    rec_if.status_byte = '0;
    rec_if.method_code = '0;
    rec_if.type_code   = '0;
    rec_if.stat_select = '0;
    res_if.ready       = 1'b0;

    req_cnt = '0; byte_sum = '0; size_lo = '1; size_hi = '0;
    cli_lo = '1; cli_hi = '0; obj_lo = '1; obj_hi = '0;
    t_lo = '1; t_hi = '0; first_t = '1; last_t = '0; seen_first = 1'b0;
    disorder_cnt = '0; server_seen = '0;
    foreach (per_server[i]) per_server[i] = '0;
    err_cnt = 0; sent_cnt = 0; got_cnt = 0; hold_left = 0;
    n_records = 0; n_stat_reads = 0; n_srv_reads = 0; n_unused = 0;
    gen_stamp = '0; gen_srv = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values, field extremes, flag thresholds, special sizes
    queue_read(wtsa_pkg::FUNC_READ_STAT, wtsa_pkg::STAT_SIZE_MIN, 8'h00);
    queue_read(wtsa_pkg::FUNC_READ_STAT, wtsa_pkg::STAT_FIRST, 8'h00);
    queue_read(wtsa_pkg::FUNC_READ_SERVER, 4'h0, 8'hFF);
    queue_record(32'h8000_0000, '0, '0, wtsa_pkg::SIZE_UNKNOWN,
                 8'h00, 8'h00, 8'h00, 8'h00);
    queue_record('1, '1, '1, 32'h7FFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // stamp goes backward, most negative size, same server twice in a row
    queue_record('0, 32'h1, 32'h2, 32'h8000_0000, 8'hFF, 8'd38, 8'd9, 8'd13);
    queue_record(32'h10, 32'h5, 32'h6, '0, 8'h80, 8'd37, 8'd8, 8'd12);
    queue_record(32'h10, 32'h5, 32'h6, 32'hFFFF_FFFE, 8'h7F, 8'hC0, 8'd0, 8'd0);
    queue_read(wtsa_pkg::FUNC_NONE, 4'hF, 8'hFF);
    for (int s = 0; s < 16; s++) queue_read(wtsa_pkg::FUNC_READ_STAT, 4'(s), 8'h00);
    queue_read(wtsa_pkg::FUNC_READ_SERVER, 4'h0, 8'hFF);
    queue_read(wtsa_pkg::FUNC_READ_SERVER, 4'h0, 8'h80);

    // sender waits here until every result is back
    while (record_queue.size() != 0 || rec_if.valid || due_results.size() != 0)
      @(negedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) record_queue.push_back(random_item());
    while (record_queue.size() != 0 || rec_if.valid || due_results.size() != 0)
      @(negedge clk);

    repeat (20) @(negedge clk);
    if (due_results.size() != 0)
      report_mismatch("results never returned", 64'(due_results.size()), '0);

    $display("Covered %0d records, %0d statistic reads, %0d server reads, %0d unused codes",
             n_records, n_stat_reads, n_srv_reads, n_unused);
    $display("Saw %0d out-of-order stamps across %0d distinct servers; %0d errors",
             disorder_cnt, server_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
